@@ rtl/core/swmm_pkg.sv @@
// swmm_pkg: shared types and constants for the sliding window mean/median filter
// no dependencies
`timescale 1ns / 1ps
package swmm_pkg;
   localparam int SAMPLE_W = 12;
   typedef logic [SAMPLE_W-1:0] sample_type;
   localparam logic [1:0] CSR_FILTER_MODE = 2'd0;
   localparam logic MODE_MEAN   = 1'b0;
   localparam logic MODE_MEDIAN = 1'b1;
endpackage

@@ rtl/core/sliding_window_mean_median_filter.sv @@
// sliding_window_mean_median_filter: windowed mean or median of 12-bit samples
// depends on swmm_pkg; holds the sample ring and a sorted copy in two memories
//
// first word: a window fill writes it into every ring and sorted slot; later words
// read the oldest sample, then one merge sweep over the sorted memory and a tail write
// one word in flight, taken only when idle; a stalled result holds the filter in its
// done state with the input not ready, and the result before it in the output register
// reset: synchronous, active high; clears mode, sets first-word flag, no memory pass
`timescale 1ns / 1ps
module sliding_window_mean_median_filter #(
   parameter int WINDOW = 50
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  swmm_pkg::sample_type  req_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output swmm_pkg::sample_type  rsp_filtered_value,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [1:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import swmm_pkg::*;

   localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUMW = SAMPLE_W + $clog2(WINDOW + 1);
   localparam int SHW = SUMW + $clog2(WINDOW);
   localparam int RW = SUMW + 1;
   localparam int PRODW = 2 * SUMW + 1;
   localparam logic [IW-1:0] LAST = IW'(WINDOW - 1);
   localparam logic [IW-1:0] MLO = IW'(WINDOW / 2 - 1);
   localparam logic [IW-1:0] MHI = IW'(WINDOW / 2);
   localparam logic [SUMW-1:0] WIN_SUM = SUMW'(WINDOW);
   // reciprocal of WINDOW, exact floor division for any window sum
   localparam longint RECIP_L =
      ((longint'(1) <<< SHW) + longint'(WINDOW) - 1) / longint'(WINDOW);
   localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

   typedef enum logic [2:0] {
      ST_IDLE, ST_FILL, ST_RDOLD, ST_SWEEP, ST_TAIL, ST_DONE
   } state_type;

   state_type       state_ff;
   logic            mode_ff, first_ff;
   logic [IW-1:0]   head_ff;          // ring slot of the oldest sample
   logic [IW-1:0]   ptr_ff;
   sample_type      new_ff, carry_ff, lo_ff, hi_ff;
   logic            rm_ff;            // oldest word already dropped from the sorted copy
   logic [SUMW-1:0] sum_ff;
   logic            rsp_valid_ff;
   sample_type      rsp_ff;

   // memories
   sample_type ring_mem [WINDOW];
   sample_type sort_mem [WINDOW];
   logic           rwe, swe;
   logic [IW-1:0]  raddr, swa, sra;
   sample_type     rwd, swd, rrd_ff, srd_ff;

   always_ff @(posedge clock) begin
      if (rwe) ring_mem[raddr] <= rwd;
      rrd_ff <= ring_mem[raddr];
   end
   always_ff @(posedge clock) begin
      if (swe) sort_mem[swa] <= swd;
      srd_ff <= sort_mem[sra];
   end

   logic cfg_wr;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_FILTER_MODE) ? {31'd0, mode_ff} : 32'd0;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_filtered_value = rsp_ff;

   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   logic [IW-1:0] ptr_nx;
   assign ptr_nx = (ptr_ff == LAST) ? '0 : ptr_ff + 1'b1;

   // merge sweep: rrd_ff holds the oldest sample, srd_ff the sorted entry ptr_ff
   logic       drop;
   sample_type merge_lo, merge_hi;
   assign drop = !rm_ff && (srd_ff == rrd_ff);
   assign merge_lo = (srd_ff < carry_ff) ? srd_ff : carry_ff;
   assign merge_hi = (srd_ff < carry_ff) ? carry_ff : srd_ff;

   logic [PRODW-1:0]  mean_prod;
   logic [SAMPLE_W:0] med_sum;
   sample_type        res_word;
   assign mean_prod = PRODW'(sum_ff) * PRODW'(RECIP);
   assign med_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign res_word = (mode_ff == MODE_MEDIAN) ? med_sum[SAMPLE_W:1]
                                              : mean_prod[SHW +: SAMPLE_W];

   always_comb begin
      rwe = 1'b0; rwd = new_ff; raddr = head_ff;
      swe = 1'b0; swd = new_ff; swa = ptr_ff; sra = '0;
      unique case (state_ff)
         ST_FILL: begin
            rwe = 1'b1; raddr = ptr_ff; swe = 1'b1;
         end
         ST_SWEEP: begin
            sra = ptr_nx;
            // entries after the dropped one move down a slot
            if (!drop) begin
               swe = 1'b1;
               swa = rm_ff ? ptr_ff - 1'b1 : ptr_ff;
               swd = merge_lo;
            end
         end
         ST_TAIL: begin
            rwe = 1'b1; swe = 1'b1; swa = LAST; swd = carry_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff <= MODE_MEAN;
         first_ff <= 1'b1;
         head_ff <= '0;
         ptr_ff <= '0;
         rm_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_wr && csr_paddr == CSR_FILTER_MODE) mode_ff <= csr_pwdata[0];
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff <= res_word;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // middle entries are caught as they are written
         if (swe && swa == MLO) lo_ff <= swd;
         if (swe && swa == MHI) hi_ff <= swd;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready) begin
                  new_ff <= req_sample;
                  carry_ff <= req_sample;
                  ptr_ff <= '0;
                  rm_ff <= 1'b0;
                  state_ff <= first_ff ? ST_FILL : ST_RDOLD;
               end
            end
            ST_FILL: begin
               ptr_ff <= ptr_nx;
               if (ptr_ff == LAST) begin
                  first_ff <= 1'b0;
                  sum_ff <= SUMW'(new_ff) * WIN_SUM;
                  state_ff <= ST_DONE;
               end
            end
            ST_RDOLD: state_ff <= ST_SWEEP;
            ST_SWEEP: begin
               if (drop) rm_ff <= 1'b1;
               else carry_ff <= merge_hi;
               ptr_ff <= ptr_nx;
               if (ptr_ff == LAST) state_ff <= ST_TAIL;
            end
            ST_TAIL: begin
               head_ff <= (head_ff == LAST) ? '0 : head_ff + 1'b1;
               sum_ff <= sum_ff + SUMW'(new_ff) - SUMW'(rrd_ff);
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result word changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != ST_IDLE)
      else $error("accepted word left no work");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FILL |-> first_ff)
      else $error("window fill after first word");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TAIL |-> rm_ff)
      else $error("oldest word missing from sorted copy");
   assert property (@(posedge clock) disable iff (reset)
      head_ff <= LAST)
      else $error("ring head out of range");
endmodule
